>>> hw/rtl/gdr_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gdr_pkg
// Types, constants and command codes shared by the grid raycaster modules.
// ----------------------------------------------------------------------------
package gdr_pkg;

  localparam int MAP_DIM_DEF       = 32;
  localparam int SCREEN_WIDTH_DEF  = 800;
  localparam int SCREEN_HEIGHT_DEF = 600;
  localparam int MAX_STEPS_DEF     = 64;

  localparam int POS_W   = 21;
  localparam int DIR_W   = 18;
  localparam int FRAC_W  = 16;
  localparam int CFG_W   = 21;
  localparam int IDX_W   = 3;
  localparam int COL_W   = 10;
  localparam int CELL_W  = 5;
  localparam int VAL_W   = 8;
  localparam int ROW_W   = 10;
  localparam int DIST_W  = 24;
  localparam int SIDE_W  = 32;
  localparam int CAM_W   = 28;
  localparam int RAY_W   = 30;
  localparam int MULA_W  = 19;
  localparam int MULB_W  = 33;
  localparam int PROD_W  = MULA_W + MULB_W;
  localparam int CRD_W   = 10;
  localparam int NUMD_W  = 28;
  localparam int NUM_W   = 44;
  localparam int DEN_W   = 30;

  localparam logic [FRAC_W:0]   Q_ONE    = {1'b1, {FRAC_W{1'b0}}};
  localparam logic [SIDE_W-1:0] SIDE_MAX = '1;
  localparam logic [DIST_W-1:0] DIST_MAX = '1;

  localparam logic [IDX_W-1:0] REG_POS_X       = 3'd0;
  localparam logic [IDX_W-1:0] REG_POS_Y       = 3'd1;
  localparam logic [IDX_W-1:0] REG_VIEW_DIR_X  = 3'd2;
  localparam logic [IDX_W-1:0] REG_VIEW_DIR_Y  = 3'd3;
  localparam logic [IDX_W-1:0] REG_CAM_PLANE_X = 3'd4;
  localparam logic [IDX_W-1:0] REG_CAM_PLANE_Y = 3'd5;

  localparam logic OPER_CAST  = 1'b0;
  localparam logic OPER_WRITE = 1'b1;

  localparam int CMD_W = 5;
  localparam logic [CMD_W-1:0] OP_NONE     = 5'd0;
  localparam logic [CMD_W-1:0] OP_CLEAR    = 5'd1;
  localparam logic [CMD_W-1:0] OP_ACCEPT   = 5'd2;
  localparam logic [CMD_W-1:0] OP_CAM_GO   = 5'd3;
  localparam logic [CMD_W-1:0] OP_MULX     = 5'd5;
  localparam logic [CMD_W-1:0] OP_MULY     = 5'd6;
  localparam logic [CMD_W-1:0] OP_RAYY     = 5'd7;
  localparam logic [CMD_W-1:0] OP_DX_GO    = 5'd8;
  localparam logic [CMD_W-1:0] OP_DX_END   = 5'd9;
  localparam logic [CMD_W-1:0] OP_DY_GO    = 5'd10;
  localparam logic [CMD_W-1:0] OP_DY_END   = 5'd11;
  localparam logic [CMD_W-1:0] OP_SIDEX    = 5'd12;
  localparam logic [CMD_W-1:0] OP_SIDEY    = 5'd13;
  localparam logic [CMD_W-1:0] OP_SIDEW    = 5'd14;
  localparam logic [CMD_W-1:0] OP_STEP     = 5'd15;
  localparam logic [CMD_W-1:0] OP_TEST     = 5'd16;
  localparam logic [CMD_W-1:0] OP_DIST_GO  = 5'd17;
  localparam logic [CMD_W-1:0] OP_DIST_END = 5'd18;
  localparam logic [CMD_W-1:0] OP_LEN_GO   = 5'd19;
  localparam logic [CMD_W-1:0] OP_LEN_END  = 5'd20;
  localparam logic [CMD_W-1:0] OP_LOAD     = 5'd21;

  typedef struct packed {
    logic              operation;
    logic [COL_W-1:0]  column;
    logic [CELL_W-1:0] cell_x;
    logic [CELL_W-1:0] cell_y;
    logic [VAL_W-1:0]  cell_value;
  } item_t;

  typedef struct packed {
    logic [COL_W-1:0]  column_out;
    logic [ROW_W-1:0]  draw_start;
    logic [ROW_W-1:0]  draw_end;
    logic              wall_side;
    logic [VAL_W-1:0]  hit_value;
    logic [DIST_W-1:0] perp_distance;
    logic              hit_found;
  } result_t;

  typedef struct packed {
    logic [CMD_W-1:0] op;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic div_done;
    logic walk_end;
    logic out_free;
  } stat_t;

endpackage
`default_nettype wire

>>> hw/rtl/gdr_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gdr_ram
// Generic single write port RAM with one registered read port.
// ----------------------------------------------------------------------------
module gdr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

>>> hw/rtl/gdr_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gdr_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module gdr_div import gdr_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [NUM_W-1:0] num,
  input  wire logic [DEN_W-1:0] den,
  output logic                  done,
  output logic      [NUM_W-1:0] quot
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [DEN_W:0]   rem;
  logic [DEN_W-1:0] den_q;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic [DEN_W:0]   rem_sh;
  logic             qbit;

  assign rem_sh = {rem[DEN_W-1:0], quot[NUM_W-1]};
  assign qbit   = rem_sh >= {1'b0, den_q};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && (cnt == CNT_W'(1));
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(NUM_W);
      end else if (busy) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quot  <= num;
      den_q <= den;
      rem   <= '0;
    end else if (busy) begin
      rem  <= qbit ? rem_sh - {1'b0, den_q} : rem_sh;
      quot <= {quot[NUM_W-2:0], qbit};
    end
  end

endmodule
`default_nettype wire

>>> hw/rtl/gdr_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gdr_ctrl
// Sequencer for map clearing, cell writes and the per-column cast.
// ----------------------------------------------------------------------------
module gdr_ctrl import gdr_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  in_valid,
  input  wire logic  in_cast,
  input  wire stat_t stat,
  output logic       in_stall,
  output cmd_t       cmd
);

  localparam logic [4:0] ST_CLR   = 5'd0;
  localparam logic [4:0] ST_IDLE  = 5'd1;
  localparam logic [4:0] ST_CAM   = 5'd2;
  localparam logic [4:0] ST_MULX  = 5'd4;
  localparam logic [4:0] ST_MULY  = 5'd5;
  localparam logic [4:0] ST_RAYY  = 5'd6;
  localparam logic [4:0] ST_DX    = 5'd7;
  localparam logic [4:0] ST_DXW   = 5'd8;
  localparam logic [4:0] ST_DY    = 5'd9;
  localparam logic [4:0] ST_DYW   = 5'd10;
  localparam logic [4:0] ST_SIDEX = 5'd11;
  localparam logic [4:0] ST_SIDEY = 5'd12;
  localparam logic [4:0] ST_SIDEW = 5'd13;
  localparam logic [4:0] ST_STEP  = 5'd14;
  localparam logic [4:0] ST_TEST  = 5'd15;
  localparam logic [4:0] ST_DIST  = 5'd16;
  localparam logic [4:0] ST_DISTW = 5'd17;
  localparam logic [4:0] ST_LEN   = 5'd18;
  localparam logic [4:0] ST_LENW  = 5'd19;
  localparam logic [4:0] ST_FIN   = 5'd20;

  logic [4:0] state;
  logic [4:0] state_next;

  assign in_stall = (state != ST_IDLE);

  always_comb begin
    state_next = state;
    cmd.op     = OP_NONE;
    unique case (state)
      ST_CLR: begin
        cmd.op = OP_CLEAR;
        if (stat.clr_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) begin
          cmd.op = OP_ACCEPT;
          if (in_cast) state_next = ST_CAM;
        end
      end
      ST_CAM: begin
        cmd.op     = OP_CAM_GO;
        state_next = ST_MULX;
      end
      ST_MULX: begin
        cmd.op     = OP_MULX;
        state_next = ST_MULY;
      end
      ST_MULY: begin
        cmd.op     = OP_MULY;
        state_next = ST_RAYY;
      end
      ST_RAYY: begin
        cmd.op     = OP_RAYY;
        state_next = ST_DX;
      end
      ST_DX: begin
        cmd.op     = OP_DX_GO;
        state_next = ST_DXW;
      end
      ST_DXW: begin
        if (stat.div_done) begin
          cmd.op     = OP_DX_END;
          state_next = ST_DY;
        end
      end
      ST_DY: begin
        cmd.op     = OP_DY_GO;
        state_next = ST_DYW;
      end
      ST_DYW: begin
        if (stat.div_done) begin
          cmd.op     = OP_DY_END;
          state_next = ST_SIDEX;
        end
      end
      ST_SIDEX: begin
        cmd.op     = OP_SIDEX;
        state_next = ST_SIDEY;
      end
      ST_SIDEY: begin
        cmd.op     = OP_SIDEY;
        state_next = ST_SIDEW;
      end
      ST_SIDEW: begin
        cmd.op     = OP_SIDEW;
        state_next = ST_STEP;
      end
      ST_STEP: begin
        cmd.op     = OP_STEP;
        state_next = ST_TEST;
      end
      ST_TEST: begin
        cmd.op     = OP_TEST;
        state_next = stat.walk_end ? ST_DIST : ST_STEP;
      end
      ST_DIST: begin
        cmd.op     = OP_DIST_GO;
        state_next = ST_DISTW;
      end
      ST_DISTW: begin
        if (stat.div_done) begin
          cmd.op     = OP_DIST_END;
          state_next = ST_LEN;
        end
      end
      ST_LEN: begin
        cmd.op     = OP_LEN_GO;
        state_next = ST_LENW;
      end
      ST_LENW: begin
        if (stat.div_done) begin
          cmd.op     = OP_LEN_END;
          state_next = ST_FIN;
        end
      end
      ST_FIN: begin
        if (stat.out_free) begin
          cmd.op     = OP_LOAD;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLR;
    end else begin
      state <= state_next;
    end
  end

endmodule
`default_nettype wire

>>> hw/rtl/gdr_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gdr_dp
// Datapath: settings, map RAM, shared multiplier and divider, DDA walk state
// and the output register.
// ----------------------------------------------------------------------------
module gdr_dp import gdr_pkg::*; #(
  parameter int MAP_DIM       = MAP_DIM_DEF,
  parameter int SCREEN_WIDTH  = SCREEN_WIDTH_DEF,
  parameter int SCREEN_HEIGHT = SCREEN_HEIGHT_DEF,
  parameter int MAX_STEPS     = MAX_STEPS_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             cfg_write,
  input  wire logic [IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0] cfg_data,
  input  wire item_t            in_data,
  input  wire cmd_t             cmd,
  input  wire logic             out_stall,
  output logic                  out_valid,
  output result_t               out_data,
  output stat_t                 stat
);

  localparam int DEPTH = MAP_DIM * MAP_DIM;
  localparam int AW    = $clog2(DEPTH);
  localparam int CNT_W = $clog2(MAX_STEPS + 1);
  localparam int RCP_SH = 22;
  localparam int RCP_W  = 40;
  localparam logic [RCP_W-1:0] CAM_RCP =
    RCP_W'(((64'd1 << (FRAC_W + 1 + RCP_SH)) + 64'(SCREEN_WIDTH) - 64'd1)
           / 64'(SCREEN_WIDTH));
  localparam logic [NUM_W-1:0] RECIP_NUM = NUM_W'(1) << SIDE_W;
  localparam logic [NUM_W-1:0] LEN_NUM   = NUM_W'(SCREEN_HEIGHT) << FRAC_W;
  localparam logic [NUM_W-1:0] HALF_H    = NUM_W'(SCREEN_HEIGHT / 2);
  localparam logic [NUM_W-1:0] FULL_H    = NUM_W'(SCREEN_HEIGHT);
  localparam logic [ROW_W-1:0] LAST_ROW  = ROW_W'(SCREEN_HEIGHT - 1);

  logic [POS_W-1:0]        pos_x, pos_y;
  logic signed [DIR_W-1:0] dir_x, dir_y, plane_x, plane_y;

  logic [COL_W-1:0]         column;
  logic signed [CAM_W-1:0]  cam;
  logic signed [PROD_W-1:0] prod;
  logic signed [RAY_W-1:0]  rx, ry;
  logic [SIDE_W-1:0]        dx, dy, sx, sy;
  logic signed [CRD_W-1:0]  mx, my;
  logic [CNT_W-1:0]         cnt;
  logic                     side, hit;
  logic [VAL_W-1:0]         val;
  logic [DIST_W-1:0]        perp_dist;
  logic [ROW_W-1:0]         row_start, row_end;
  logic [AW-1:0]            clr;

  logic [COL_W+RCP_W-1:0]   cam_prod;
  logic signed [MULA_W-1:0] mul_a;
  logic signed [MULB_W-1:0] mul_b;
  logic signed [PROD_W-1:0] prod_next;
  logic [SIDE_W-1:0]        prod_sat;
  logic [RAY_W-1:0]         mag_rx, mag_ry, mag_r;
  logic [FRAC_W:0]          fxs, fys;
  logic                     take_x;
  logic signed [CRD_W-1:0]  mx_next, my_next;
  logic [SIDE_W:0]          sx_sum, sy_sum;
  logic                     in_grid, hit_now;
  logic signed [NUMD_W-1:0] num_d;
  logic [NUMD_W-1:0]        mag_num;
  logic [NUM_W-2:0]         half;
  logic [NUM_W-1:0]         end_sum;

  logic             div_start;
  logic [NUM_W-1:0] div_num;
  logic [DEN_W-1:0] div_den;
  logic             div_done;
  logic [NUM_W-1:0] quot;

  logic             ram_we;
  logic [AW-1:0]    ram_waddr, ram_raddr;
  logic [VAL_W-1:0] ram_wdata, ram_rdata;

  gdr_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quot  (quot)
  );

  gdr_ram #(.WIDTH(VAL_W), .DEPTH(DEPTH)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign cam_prod = (COL_W+RCP_W)'(column) * (COL_W+RCP_W)'(CAM_RCP);

  assign mag_rx = rx[RAY_W-1] ? RAY_W'(-rx) : RAY_W'(rx);
  assign mag_ry = ry[RAY_W-1] ? RAY_W'(-ry) : RAY_W'(ry);
  assign mag_r  = side ? mag_ry : mag_rx;
  assign fxs = rx[RAY_W-1] ? {1'b0, pos_x[FRAC_W-1:0]} : Q_ONE - {1'b0, pos_x[FRAC_W-1:0]};
  assign fys = ry[RAY_W-1] ? {1'b0, pos_y[FRAC_W-1:0]} : Q_ONE - {1'b0, pos_y[FRAC_W-1:0]};

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (cmd.op)
      OP_MULX: begin
        mul_a = MULA_W'(plane_x);
        mul_b = MULB_W'(cam);
      end
      OP_MULY: begin
        mul_a = MULA_W'(plane_y);
        mul_b = MULB_W'(cam);
      end
      OP_SIDEX: begin
        mul_a = $signed({2'b00, fxs});
        mul_b = $signed({1'b0, dx});
      end
      OP_SIDEY: begin
        mul_a = $signed({2'b00, fys});
        mul_b = $signed({1'b0, dy});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod_next = mul_a * mul_b;
  assign prod_sat  = (|prod[PROD_W-1:FRAC_W+SIDE_W]) ? SIDE_MAX
                                                     : prod[FRAC_W+SIDE_W-1:FRAC_W];

  assign take_x  = sx < sy;
  assign mx_next = take_x ? (rx[RAY_W-1] ? mx - CRD_W'(1) : mx + CRD_W'(1)) : mx;
  assign my_next = take_x ? my : (ry[RAY_W-1] ? my - CRD_W'(1) : my + CRD_W'(1));
  assign sx_sum  = {1'b0, sx} + {1'b0, dx};
  assign sy_sum  = {1'b0, sy} + {1'b0, dy};
  assign in_grid = !mx[CRD_W-1] && !my[CRD_W-1]
                   && (mx < $signed(CRD_W'(MAP_DIM))) && (my < $signed(CRD_W'(MAP_DIM)));
  assign hit_now = !in_grid || (ram_rdata != '0);

  always_comb begin
    if (side) begin
      num_d = $signed({{(NUMD_W-CRD_W-FRAC_W){my[CRD_W-1]}}, my, {FRAC_W{1'b0}}})
              - $signed(NUMD_W'(pos_y))
              + (ry[RAY_W-1] ? $signed(NUMD_W'(Q_ONE)) : $signed(NUMD_W'(0)));
    end else begin
      num_d = $signed({{(NUMD_W-CRD_W-FRAC_W){mx[CRD_W-1]}}, mx, {FRAC_W{1'b0}}})
              - $signed(NUMD_W'(pos_x))
              + (rx[RAY_W-1] ? $signed(NUMD_W'(Q_ONE)) : $signed(NUMD_W'(0)));
    end
  end
  assign mag_num = num_d[NUMD_W-1] ? NUMD_W'(-num_d) : NUMD_W'(num_d);

  assign half    = quot[NUM_W-1:1];
  assign end_sum = {1'b0, half} + HALF_H;

  always_comb begin
    div_start = 1'b0;
    div_num   = '0;
    div_den   = '0;
    unique case (cmd.op)
      OP_DX_GO: begin
        div_start = 1'b1;
        div_num   = RECIP_NUM;
        div_den   = DEN_W'(mag_rx);
      end
      OP_DY_GO: begin
        div_start = 1'b1;
        div_num   = RECIP_NUM;
        div_den   = DEN_W'(mag_ry);
      end
      OP_DIST_GO: begin
        div_start = 1'b1;
        div_num   = {mag_num, {FRAC_W{1'b0}}};
        div_den   = DEN_W'(mag_r);
      end
      OP_LEN_GO: begin
        div_start = 1'b1;
        div_num   = LEN_NUM;
        div_den   = DEN_W'(perp_dist);
      end
      default: begin
        div_start = 1'b0;
      end
    endcase
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = clr;
    ram_wdata = '0;
    if (cmd.op == OP_CLEAR) begin
      ram_we = 1'b1;
    end else if (cmd.op == OP_ACCEPT && in_data.operation == OPER_WRITE) begin
      ram_we    = (32'(in_data.cell_x) < 32'(MAP_DIM)) && (32'(in_data.cell_y) < 32'(MAP_DIM));
      ram_waddr = AW'(32'(in_data.cell_y) * 32'(MAP_DIM) + 32'(in_data.cell_x));
      ram_wdata = in_data.cell_value;
    end
  end

  assign ram_raddr = AW'(32'(my_next[CRD_W-2:0]) * 32'(MAP_DIM) + 32'(mx_next[CRD_W-2:0]));

  assign stat.clr_last = (clr == AW'(DEPTH - 1));
  assign stat.div_done = div_done;
  assign stat.walk_end = hit_now || (cnt == CNT_W'(MAX_STEPS));
  assign stat.out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      pos_x   <= '0;
      pos_y   <= '0;
      dir_x   <= '0;
      dir_y   <= '0;
      plane_x <= '0;
      plane_y <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_POS_X:       pos_x   <= cfg_data[POS_W-1:0];
        REG_POS_Y:       pos_y   <= cfg_data[POS_W-1:0];
        REG_VIEW_DIR_X:  dir_x   <= cfg_data[DIR_W-1:0];
        REG_VIEW_DIR_Y:  dir_y   <= cfg_data[DIR_W-1:0];
        REG_CAM_PLANE_X: plane_x <= cfg_data[DIR_W-1:0];
        REG_CAM_PLANE_Y: plane_y <= cfg_data[DIR_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.op == OP_CLEAR) begin
        clr <= clr + AW'(1);
      end
      if (cmd.op == OP_LOAD) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      OP_ACCEPT:  column <= in_data.column;
      OP_CAM_GO:  cam <= $signed(CAM_W'(cam_prod >> RCP_SH)) - $signed(CAM_W'(Q_ONE));
      OP_MULX:    prod <= prod_next;
      OP_MULY: begin
        rx   <= RAY_W'(dir_x) + prod[FRAC_W+RAY_W-1:FRAC_W];
        prod <= prod_next;
      end
      OP_RAYY:    ry <= RAY_W'(dir_y) + prod[FRAC_W+RAY_W-1:FRAC_W];
      OP_DX_END:  dx <= (mag_rx == '0 || (|quot[NUM_W-1:SIDE_W])) ? SIDE_MAX : quot[SIDE_W-1:0];
      OP_DY_END:  dy <= (mag_ry == '0 || (|quot[NUM_W-1:SIDE_W])) ? SIDE_MAX : quot[SIDE_W-1:0];
      OP_SIDEX:   prod <= prod_next;
      OP_SIDEY: begin
        sx   <= prod_sat;
        prod <= prod_next;
      end
      OP_SIDEW: begin
        sy   <= prod_sat;
        mx   <= CRD_W'(pos_x[POS_W-1:FRAC_W]);
        my   <= CRD_W'(pos_y[POS_W-1:FRAC_W]);
        cnt  <= '0;
        side <= 1'b0;
        hit  <= 1'b0;
        val  <= '0;
      end
      OP_STEP: begin
        if (take_x) begin
          sx   <= sx_sum[SIDE_W] ? SIDE_MAX : sx_sum[SIDE_W-1:0];
          side <= 1'b0;
        end else begin
          sy   <= sy_sum[SIDE_W] ? SIDE_MAX : sy_sum[SIDE_W-1:0];
          side <= 1'b1;
        end
        mx  <= mx_next;
        my  <= my_next;
        cnt <= cnt + CNT_W'(1);
      end
      OP_TEST: begin
        hit <= hit_now;
        val <= in_grid ? ram_rdata : '0;
      end
      OP_DIST_END: begin
        perp_dist <= (mag_r == '0 || (|quot[NUM_W-1:DIST_W])) ? DIST_MAX : quot[DIST_W-1:0];
      end
      OP_LEN_END: begin
        if (perp_dist == '0) begin
          row_start <= '0;
          row_end   <= LAST_ROW;
        end else begin
          row_start <= ({1'b0, half} >= HALF_H) ? '0 : ROW_W'(HALF_H - {1'b0, half});
          row_end   <= (end_sum >= FULL_H) ? LAST_ROW : ROW_W'(end_sum);
        end
      end
      OP_LOAD: begin
        out_data.column_out <= column;
        out_data.hit_found  <= hit;
        if (hit) begin
          out_data.draw_start    <= row_start;
          out_data.draw_end      <= row_end;
          out_data.wall_side     <= side;
          out_data.hit_value     <= val;
          out_data.perp_distance <= perp_dist;
        end else begin
          out_data.draw_start    <= '0;
          out_data.draw_end      <= '0;
          out_data.wall_side     <= 1'b0;
          out_data.hit_value     <= '0;
          out_data.perp_distance <= DIST_MAX;
        end
      end
      default: ;
    endcase
  end

  a_miss_far: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> (out_data.hit_found || out_data.perp_distance == DIST_MAX))
    else $error("miss result without saturated distance");

  a_one_axis: assert property (@(posedge clk) disable iff (rst)
    cmd.op == OP_STEP |=> ($stable(mx) || $stable(my)))
    else $error("walk step moved along both axes");

  a_side_grow: assert property (@(posedge clk) disable iff (rst)
    cmd.op == OP_STEP |=> (sx >= $past(sx) && sy >= $past(sy)))
    else $error("side distance decreased");

endmodule
`default_nettype wire

>>> hw/rtl/grid_dda_raycast_column.sv
`default_nettype none
// ----------------------------------------------------------------------------
// grid_dda_raycast_column
// DDA grid raycaster producing one wall span per screen column.
// ----------------------------------------------------------------------------
// After reset the block sweeps the MAP_DIM*MAP_DIM map RAM to zero, one cell
// a cycle, and stalls its input until done. A cell write transaction is
// taken without leaving the idle state. A cast forms the camera offset by
// a constant reciprocal multiply, then runs four divisions on one shared
// radix-2 divider plus the DDA walk, in which each grid step passes through
// a step state and a test state because it waits on the registered map
// read; the walk takes at most MAX_STEPS steps. A finished cast waits in its
// last state while the previous result still waits in the output register.
// One item is in work at a time; a finished result waits in the output
// register while the next transaction is taken.
// ----------------------------------------------------------------------------
module grid_dda_raycast_column import gdr_pkg::*; #(
  parameter int MAP_DIM       = MAP_DIM_DEF,
  parameter int SCREEN_WIDTH  = SCREEN_WIDTH_DEF,
  parameter int SCREEN_HEIGHT = SCREEN_HEIGHT_DEF,
  parameter int MAX_STEPS     = MAX_STEPS_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             cfg_write,
  input  wire logic [IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0] cfg_data,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire item_t            in_data,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output result_t               out_data
);

  cmd_t  cmd;
  stat_t stat;

  gdr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_cast  (in_data.operation == OPER_CAST),
    .stat     (stat),
    .in_stall (in_stall),
    .cmd      (cmd)
  );

  gdr_dp #(
    .MAP_DIM       (MAP_DIM),
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT),
    .MAX_STEPS     (MAX_STEPS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .cmd       (cmd),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data),
    .stat      (stat)
  );

endmodule
`default_nettype wire

>>> verif/raycast_checker.sv
// ----------------------------------------------------------------------------
// raycast_checker
// Watches the configuration port and both channels of the grid raycaster. It
// keeps its own map and registers, works out the wall span for each accepted
// cast, and compares every result transaction field by field with the oldest
// one expected.
// ----------------------------------------------------------------------------
module raycast_checker import gdr_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_write,
  input  logic [IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0] cfg_data,
  input  logic             in_valid,
  input  logic             in_stall,
  input  item_t            in_data,
  input  logic             out_valid,
  input  logic             out_stall,
  input  result_t          out_data,
  output int               fail_count,
  output int               pending,
  output int               hit_count
);

  localparam longint QONE  = 65536;
  localparam longint SMAX  = 64'hFFFF_FFFF;
  localparam longint DMAX  = 64'hFF_FFFF;

  logic [VAL_W-1:0] grid_map [MAP_DIM_DEF*MAP_DIM_DEF];
  logic [POS_W-1:0] view_x, view_y;
  logic [DIR_W-1:0] dir_x, dir_y, plane_x, plane_y;
  result_t          span_queue [$];

  function automatic longint abs64(longint v);
    return v < 0 ? -v : v;
  endfunction

  function automatic longint inv_delta(longint c);
    longint q;
    if (c == 0) return SMAX;
    q = (longint'(1) << 32) / abs64(c);
    return q > SMAX ? SMAX : q;
  endfunction

  function automatic result_t cast_column(logic [COL_W-1:0] col);
    result_t res;
    longint cam, rx, ry, dx, dy, sx, sy, num, r, wall_dist, len, top, bot;
    longint fx, fy;
    int mx, my, stx, sty, side, hit, val;
    side = 0;
    hit = 0;
    val = 0;
    cam = (longint'(col) * 2 * QONE) / SCREEN_WIDTH_DEF - QONE;
    rx = longint'($signed(dir_x)) + ((longint'($signed(plane_x)) * cam) >>> 16);
    ry = longint'($signed(dir_y)) + ((longint'($signed(plane_y)) * cam) >>> 16);
    mx = int'(view_x >> 16);
    my = int'(view_y >> 16);
    fx = longint'(view_x[15:0]);
    fy = longint'(view_y[15:0]);
    dx = inv_delta(rx);
    dy = inv_delta(ry);
    if (rx < 0) begin
      stx = -1; sx = (fx * dx) >> 16;
    end else begin
      stx = 1;  sx = ((QONE - fx) * dx) >> 16;
    end
    if (ry < 0) begin
      sty = -1; sy = (fy * dy) >> 16;
    end else begin
      sty = 1;  sy = ((QONE - fy) * dy) >> 16;
    end
    if (sx > SMAX) sx = SMAX;
    if (sy > SMAX) sy = SMAX;
    for (int n = 0; n < MAX_STEPS_DEF && hit == 0; n++) begin
      if (sx < sy) begin
        sx = sx + dx > SMAX ? SMAX : sx + dx;
        mx += stx;
        side = 0;
      end else begin
        sy = sy + dy > SMAX ? SMAX : sy + dy;
        my += sty;
        side = 1;
      end
      if (mx < 0 || my < 0 || mx >= MAP_DIM_DEF || my >= MAP_DIM_DEF) begin
        hit = 1;
        val = 0;
      end else if (grid_map[my*MAP_DIM_DEF + mx] != 0) begin
        hit = 1;
        val = grid_map[my*MAP_DIM_DEF + mx];
      end
    end
    res = '0;
    res.column_out = col;
    if (hit == 0) begin
      res.perp_distance = DIST_MAX;
      return res;
    end
    if (side == 0) begin
      num = longint'(mx) * QONE - longint'(view_x) + (stx < 0 ? QONE : 0);
      r = rx;
    end else begin
      num = longint'(my) * QONE - longint'(view_y) + (sty < 0 ? QONE : 0);
      r = ry;
    end
    if (r == 0) begin
      wall_dist = DMAX;
    end else begin
      wall_dist = (abs64(num) << 16) / abs64(r);
      if (wall_dist > DMAX) wall_dist = DMAX;
    end
    if (wall_dist == 0) begin
      top = 0;
      bot = SCREEN_HEIGHT_DEF - 1;
    end else begin
      len = (longint'(SCREEN_HEIGHT_DEF) * QONE) / wall_dist;
      top = SCREEN_HEIGHT_DEF / 2 - len / 2;
      bot = len / 2 + SCREEN_HEIGHT_DEF / 2;
      if (top < 0) top = 0;
      if (bot >= SCREEN_HEIGHT_DEF) bot = SCREEN_HEIGHT_DEF - 1;
    end
    res.draw_start    = top[ROW_W-1:0];
    res.draw_end      = bot[ROW_W-1:0];
    res.wall_side     = side[0];
    res.hit_value     = val[VAL_W-1:0];
    res.perp_distance = wall_dist[DIST_W-1:0];
    res.hit_found     = 1'b1;
    return res;
  endfunction

  assign pending = span_queue.size();

  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      foreach (grid_map[i]) grid_map[i] = '0;
      {view_x, view_y, dir_x, dir_y, plane_x, plane_y} = '0;
      span_queue.delete();
      fail_count = 0;
      hit_count = 0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          REG_POS_X:       view_x  = cfg_data[POS_W-1:0];
          REG_POS_Y:       view_y  = cfg_data[POS_W-1:0];
          REG_VIEW_DIR_X:  dir_x   = cfg_data[DIR_W-1:0];
          REG_VIEW_DIR_Y:  dir_y   = cfg_data[DIR_W-1:0];
          REG_CAM_PLANE_X: plane_x = cfg_data[DIR_W-1:0];
          REG_CAM_PLANE_Y: plane_y = cfg_data[DIR_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        if (in_data.operation == OPER_WRITE)
          grid_map[in_data.cell_y*MAP_DIM_DEF + in_data.cell_x] = in_data.cell_value;
        else
          span_queue.push_back(cast_column(in_data.column));
      end
      if (out_valid && !out_stall) begin
        if (span_queue.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) $display("checker: unexpected result %p", out_data);
        end else begin
          want = span_queue.pop_front();
          if (out_data.hit_found) hit_count++;
          if (out_data !== want) begin
            fail_count++;
            if (fail_count <= 10)
              $display("checker: mismatch\n  expected %p\n  actual   %p", want, out_data);
          end
        end
      end
    end
  end

endmodule

>>> verif/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives the grid raycaster with map writes and column casts under several
// viewer settings, with random idling on both channels, a long output hold-off
// and quiet pauses for register writes. The checker beside the block predicts
// and compares every result.
// ----------------------------------------------------------------------------
module testbench;
  import gdr_pkg::*;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             cfg_write = 1'b0;
  logic [IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;
  logic             in_valid = 1'b0;
  logic             in_stall;
  item_t            in_data = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  result_t          out_data;
  int               fail_count, pending, hit_count;
  int               snd_pct = 0, rcv_pct = 0, hold_cycles = 0;
  int               casts = 0, writes = 0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  grid_dda_raycast_column u_dut (
    .clk, .rst, .cfg_write, .cfg_index, .cfg_data,
    .in_valid, .in_stall, .in_data, .out_valid, .out_stall, .out_data
  );

  raycast_checker u_chk (
    .clk, .rst, .cfg_write, .cfg_index, .cfg_data,
    .in_valid, .in_stall, .in_data, .out_valid, .out_stall, .out_data,
    .fail_count, .pending, .hit_count
  );

  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      out_stall <= 1'b1;
      hold_cycles <= hold_cycles - 1;
    end else begin
      out_stall <= ($urandom_range(99) < rcv_pct);
    end
  end

  task automatic send(item_t it);
    while ($urandom_range(99) < snd_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_data = it;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    in_valid = 1'b0;
    if (it.operation == OPER_CAST) casts++;
    else writes++;
  endtask

  task automatic cast(int col);
    item_t it;
    it = '0;
    it.operation = OPER_CAST;
    it.column = COL_W'(col);
    send(it);
  endtask

  task automatic put_cell(int x, int y, int v);
    item_t it;
    it = '0;
    it.operation = OPER_WRITE;
    it.cell_x = CELL_W'(x);
    it.cell_y = CELL_W'(y);
    it.cell_value = VAL_W'(v);
    send(it);
  endtask

  task automatic drain();
    while (pending != 0) @(negedge clk);
    repeat (400) @(negedge clk);
  endtask

  task automatic set_reg(logic [IDX_W-1:0] idx, int val);
    cfg_write = 1'b1;
    cfg_index = idx;
    cfg_data = CFG_W'(val);
    @(negedge clk);
    cfg_write = 1'b0;
  endtask

  task automatic set_view(int px, int py, int vx, int vy, int cx, int cy);
    drain();
    set_reg(REG_POS_X, px);
    set_reg(REG_POS_Y, py);
    set_reg(REG_VIEW_DIR_X, vx & 'h3FFFF);
    set_reg(REG_VIEW_DIR_Y, vy & 'h3FFFF);
    set_reg(REG_CAM_PLANE_X, cx & 'h3FFFF);
    set_reg(REG_CAM_PLANE_Y, cy & 'h3FFFF);
  endtask

  function automatic int rand_dir();
    case ($urandom_range(5))
      0: return -131072;
      1: return 131071;
      2: return 0;
      default: return int'($urandom_range(262143)) - 131072;
    endcase
  endfunction

  initial begin
    item_t it;
    repeat (9) @(negedge clk);
    rst = 1'b0;

    set_view(16*65536 + 32768, 16*65536 + 32768, 65536, 0, 0, 43253);
    cast(0);
    cast(399);
    cast(799);
    cast(1023);
    put_cell(0, 0, 255);
    put_cell(31, 31, 1);
    put_cell(20, 16, 7);
    put_cell(20, 17, 128);
    cast(400);
    cast(600);
    put_cell(20, 16, 0);
    cast(400);
    set_view(16*65536, 16*65536 + 32768, -65536, 0, 0, 0);
    put_cell(15, 16, 9);
    cast(400);
    put_cell(15, 16, 0);
    set_view(0, 0, 0, 0, 0, 0);
    cast(0);
    cast(512);
    set_view(2097151, 2097151, 131071, -131072, -131072, 131071);
    cast(0);
    cast(799);
    cast(1023);

    for (int n = 0; n < 750; n++) begin
      if (n == 250) begin
        snd_pct = 62; rcv_pct = 10;
      end else if (n == 500) begin
        snd_pct = 0; rcv_pct = 0;
      end else if (n == 0) begin
        snd_pct = 10; rcv_pct = 62;
      end
      if (n == 120 || n == 620) hold_cycles = 3000;
      if (n % 60 == 0)
        set_view($urandom_range(2097151), $urandom_range(2097151),
                 rand_dir(), rand_dir(), rand_dir(), rand_dir());
      it = item_t'($bits(item_t)'({$urandom(), $urandom()}));
      if ($urandom_range(99) < 30) begin
        it.operation = OPER_WRITE;
        if ($urandom_range(3) == 0) it.cell_value = '0;
      end else begin
        it.operation = OPER_CAST;
      end
      send(it);
    end

    drain();
    $display("testbench: %0d casts (%0d walls hit) and %0d map writes checked",
             casts, hit_count, writes);
    if (fail_count == 0 && pending == 0)
      $display("testbench: done, clean");
    else
      $display("testbench: done, errors");
    $finish;
  end

  initial begin
    #20000000;
    $display("testbench: done, errors");
    $finish;
  end

endmodule
